FILE: hw/rtl/kpes_pkg.sv
// Shared types and constants of the key press event scanner.
`default_nettype none

package kpes_pkg;

   // Number of scanned keys and the width of the level word.
   localparam int KEY_COUNT   = 6;
   localparam int LEVEL_W     = 6;
   localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int KEY_FIELD_W = 3;
   localparam int KIND_W      = 3;
   localparam int COUNT_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT     = 2'd2;

   // Reset values of the timing registers.
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET   = 16'd3;
   localparam logic [COUNT_W-1:0] LONG_PRESS_RESET = 16'd100;
   localparam logic [COUNT_W-1:0] REPEAT_RESET     = 16'd20;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   // Phase of one key, one-hot.
   typedef enum logic [3:0] {
      PH_WAIT     = 4'b0001,
      PH_DEBOUNCE = 4'b0010,
      PH_LONG     = 4'b0100,
      PH_REPEAT   = 4'b1000
   } phase_type;

   // Kind of a reported event.
   typedef enum logic [KIND_W-1:0] {
      EV_CLICK        = 3'd0,
      EV_CLICK_RELEASE = 3'd1,
      EV_LONG_PRESS   = 3'd2,
      EV_REPEAT       = 3'd3,
      EV_LONG_RELEASE = 3'd4
   } event_kind_type;

   // Timing limits shared by all lanes.
   typedef struct packed {
      logic [COUNT_W-1:0] debounce_ticks;
      logic [COUNT_W-1:0] long_press_ticks;
      logic [COUNT_W-1:0] repeat_ticks;
   } cfg_type;

   // What one lane found on the current tick.
   typedef struct packed {
      logic           fire;
      event_kind_type kind;
   } lane_event_type;

endpackage

`default_nettype wire

FILE: hw/rtl/kpes_lane.sv
// Phase machine and hold counter of one key.
`default_nettype none

module kpes_lane
   import kpes_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           tick_accept,
   input  wire logic           pressed,
   input  wire cfg_type        cfg,
   output lane_event_type      lane_event
);

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_inc;
   logic [COUNT_W-1:0] limit;
   logic               reached;

   // Saturating increment and compare against the limit of this phase.
   always_comb begin
      count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
      case (phase_ff)
         PH_DEBOUNCE: limit = cfg.debounce_ticks;
         PH_LONG:     limit = cfg.long_press_ticks;
         default:     limit = cfg.repeat_ticks;
      endcase
      reached = (count_inc >= limit);
   end

   // Next phase, next count and the event of this tick.
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      lane_event.fire = 1'b0;
      lane_event.kind = EV_CLICK;
      if (tick_accept) begin
         case (phase_ff)
            PH_WAIT: begin
               if (pressed) begin
                  phase_in = PH_DEBOUNCE;
                  count_in = '0;
               end
            end
            PH_DEBOUNCE: begin
               if (!pressed) begin
                  phase_in = PH_WAIT;
                  count_in = '0;
               end else if (reached) begin
                  phase_in        = PH_LONG;
                  count_in        = '0;
                  lane_event.fire = 1'b1;
                  lane_event.kind = EV_CLICK;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_LONG: begin
               if (!pressed) begin
                  phase_in        = PH_WAIT;
                  count_in        = '0;
                  lane_event.fire = 1'b1;
                  lane_event.kind = EV_CLICK_RELEASE;
               end else if (reached) begin
                  phase_in        = PH_REPEAT;
                  count_in        = '0;
                  lane_event.fire = 1'b1;
                  lane_event.kind = EV_LONG_PRESS;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_REPEAT: begin
               if (!pressed) begin
                  phase_in        = PH_WAIT;
                  count_in        = '0;
                  lane_event.fire = 1'b1;
                  lane_event.kind = EV_LONG_RELEASE;
               end else if (reached) begin
                  count_in        = '0;
                  lane_event.fire = 1'b1;
                  lane_event.kind = EV_REPEAT;
               end else begin
                  count_in = count_inc;
               end
            end
            default: begin
               phase_in = PH_WAIT;
               count_in = '0;
            end
         endcase
      end
   end

   // Phase and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // A waiting key has a cleared counter.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT) |-> (count_ff == '0))
      else $error("kpes_lane: counter not cleared while waiting");

   // A release always returns the key to waiting.
   assert property (@(posedge clock) disable iff (reset)
      (tick_accept && !pressed) |=> (phase_ff == PH_WAIT))
      else $error("kpes_lane: release did not return to waiting");

endmodule

`default_nettype wire

FILE: hw/rtl/kpes_merge.sv
// Collects the lane events of one tick and sends them out in key order.
`default_nettype none

module kpes_merge
   import kpes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  tick_accept,
   input  wire lane_event_type        lane_events [KEY_COUNT],
   output logic                       idle,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] key_index, [5:3] event_kind, [7:6] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic [KEY_COUNT-1:0] pend_ff, pend_in;
   event_kind_type       kind_ff [KEY_COUNT];
   logic                 out_valid_ff, out_valid_in;
   logic [KEY_FIELD_W-1:0] out_key_ff;
   event_kind_type       out_kind_ff;
   logic                 out_last_ff;
   logic [KEY_IDX_W-1:0] sel;
   logic [KEY_COUNT-1:0] rest;
   logic                 out_free;
   logic                 load;

   // Lowest pending key and what remains after it.
   always_comb begin
      sel = '0;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            sel = KEY_IDX_W'(k);
         end
      end
      rest = pend_ff & ~(KEY_COUNT'(1) << sel);
   end

   // The output register takes a new word when empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;
   assign load     = out_free && (pend_ff != '0);
   assign idle     = (pend_ff == '0);

   always_comb begin
      pend_in = pend_ff;
      if (tick_accept) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            pend_in[k] = lane_events[k].fire;
         end
      end else if (load) begin
         pend_in = rest;
      end
      out_valid_in = load ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
   end

   // Pending events and output register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Event kinds are captured with the tick; output word on load.
   always_ff @(posedge clock) begin
      if (tick_accept) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            kind_ff[k] <= lane_events[k].kind;
         end
      end
      if (load) begin
         out_key_ff  <= KEY_FIELD_W'(sel);
         out_kind_ff <= kind_ff[sel];
         out_last_ff <= (rest == '0);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_kind_ff, out_key_ff};
   assign rsp_tlast  = out_last_ff;

   // Each word moved out removes exactly one pending event.
   assert property (@(posedge clock) disable iff (reset)
      (load && !tick_accept) |=>
         ($countones(pend_ff) == $countones($past(pend_ff)) - 1))
      else $error("kpes_merge: pending count did not drop by one");

   // The word marked last leaves nothing pending.
   assert property (@(posedge clock) disable iff (reset)
      (load && (rest == '0)) |=> (pend_ff == '0))
      else $error("kpes_merge: events left after the last word");

   // A new tick never lands on undelivered events.
   assert property (@(posedge clock) disable iff (reset)
      tick_accept |-> (pend_ff == '0))
      else $error("kpes_merge: tick accepted with events pending");

endmodule

`default_nettype wire

FILE: hw/rtl/key_press_event_scanner.sv
// Top level of the key press event scanner: lanes, merge and timing registers.
//
// Usage: each word on the req_ channel is one scan tick; req_tdata[5:0] holds the
// pressed level of keys 0 to 5. Every key has its own lane with a phase machine
// (waiting, debouncing, awaiting long press, repeating) and a 16-bit hold counter.
// The lanes update together when a tick is accepted, and the merge stage sends
// their events on the rsp_ channel in ascending key order, one word per cycle:
// key index and event kind in rsp_tdata, rsp_tlast on the final event of the tick.
// A tick without events produces no word.
// The events of a tick are registered as pending on the accept edge and then move
// through the output register. A tick with events holds req_tready low while the
// merge stage moves them into the output register; ticks without events are
// accepted every cycle. The output register lets a new tick in while the last
// event of the previous one still waits; a stall on rsp_tready stops the drain
// and, once events are pending, the input.
// Timing registers are written through csr_: index 0 debounce, 1 long press,
// 2 repeat; other indexes are ignored. Write them only while no tick is in flight.
// Reset puts every key in waiting with a cleared counter and loads the register
// defaults 3, 100 and 20.
`default_nettype none

module key_press_event_scanner
   import kpes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [5:0] key_levels, [7:6] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] key_index, [5:3] event_kind, [7:6] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           tick_accept;
   logic           merge_idle;
   lane_event_type lane_events [KEY_COUNT];

   // Timing register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_ticks   = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_ticks = csr_wdata;
            CSR_REPEAT:     cfg_in.repeat_ticks     = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= LONG_PRESS_RESET;
         cfg_ff.repeat_ticks     <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A tick enters when no event of the previous one is pending.
   assign req_tready  = merge_idle;
   assign tick_accept = req_tvalid && req_tready;

   // One lane per key; keys beyond the level word are never pressed.
   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
      logic pressed;
      if (k < LEVEL_W) begin : g_in
         assign pressed = req_tdata[k];
      end else begin : g_none
         assign pressed = 1'b0;
      end
      kpes_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .tick_accept (tick_accept),
         .pressed     (pressed),
         .cfg         (cfg_ff),
         .lane_event  (lane_events[k])
      );
   end

   // Event serializer and output register.
   kpes_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .lane_events (lane_events),
      .idle        (merge_idle),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: verif/tb_key_press_event_scanner.sv
// Self-checking testbench for the key press event scanner with a per-key event predictor.
`timescale 1ns / 100ps

module tb_key_press_event_scanner
   import kpes_pkg::*;
();

   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int PHASE_TICKS     = 70;
   localparam int REPORT_LIMIT    = 40;
   localparam int HOLD_CAP        = 60;

   // Index that decodes to no register; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // One event as the result channel carries it.
   typedef struct {
      logic [KEY_FIELD_W-1:0] key;
      event_kind_type         kind;
      logic                   last;
   } scan_event_type;

   // Tracks every key's phase and hold counter and keeps the events still owed.
   class key_event_tracker;
      cfg_type            cfg;
      phase_type          phase [KEY_COUNT];
      logic [COUNT_W-1:0] hold [KEY_COUNT];
      scan_event_type     owed_events [$];
      int                 errors;

      function new();
         cfg.debounce_ticks   = DEBOUNCE_RESET;
         cfg.long_press_ticks = LONG_PRESS_RESET;
         cfg.repeat_ticks     = REPEAT_RESET;
         for (int k = 0; k < KEY_COUNT; k++) begin
            phase[k] = PH_WAIT;
            hold[k]  = '0;
         end
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_DEBOUNCE:   cfg.debounce_ticks = value;
            CSR_LONG_PRESS: cfg.long_press_ticks = value;
            CSR_REPEAT:     cfg.repeat_ticks = value;
            default: ;
         endcase
      endfunction

      // Counts one held tick, saturating, and tells whether the limit is met.
      // A limit of zero is met on the first counted tick.
      function bit count_hits(int k, logic [COUNT_W-1:0] limit);
         logic [COUNT_W:0] next_count;
         next_count = {1'b0, hold[k]} + 1'b1;
         if (next_count > {1'b0, COUNT_MAX}) begin
            next_count = {1'b0, COUNT_MAX};
         end
         hold[k] = next_count[COUNT_W-1:0];
         return next_count >= {1'b0, limit};
      endfunction

      // Steps every key on one accepted scan tick and queues its events in key order.
      function void note_tick(logic [LEVEL_W-1:0] levels);
         scan_event_type fresh [$];
         scan_event_type ev;
         event_kind_type kind;
         bit             fire;
         bit             pressed;
         for (int k = 0; k < KEY_COUNT; k++) begin
            pressed = levels[k];
            fire = 1'b0;
            kind = EV_CLICK;
            case (phase[k])
               PH_WAIT: begin
                  if (pressed) begin
                     phase[k] = PH_DEBOUNCE;
                     hold[k]  = '0;
                  end
               end
               PH_DEBOUNCE: begin
                  if (!pressed) begin
                     phase[k] = PH_WAIT;
                     hold[k]  = '0;
                  end else if (count_hits(k, cfg.debounce_ticks)) begin
                     phase[k] = PH_LONG;
                     hold[k]  = '0;
                     fire = 1'b1;
                     kind = EV_CLICK;
                  end
               end
               PH_LONG: begin
                  if (!pressed) begin
                     phase[k] = PH_WAIT;
                     hold[k]  = '0;
                     fire = 1'b1;
                     kind = EV_CLICK_RELEASE;
                  end else if (count_hits(k, cfg.long_press_ticks)) begin
                     phase[k] = PH_REPEAT;
                     hold[k]  = '0;
                     fire = 1'b1;
                     kind = EV_LONG_PRESS;
                  end
               end
               default: begin
                  if (!pressed) begin
                     phase[k] = PH_WAIT;
                     hold[k]  = '0;
                     fire = 1'b1;
                     kind = EV_LONG_RELEASE;
                  end else if (count_hits(k, cfg.repeat_ticks)) begin
                     hold[k] = '0;
                     fire = 1'b1;
                     kind = EV_REPEAT;
                  end
               end
            endcase
            if (fire) begin
               ev.key  = k[KEY_FIELD_W-1:0];
               ev.kind = kind;
               ev.last = 1'b0;
               fresh.push_back(ev);
            end
         end
         // The final event of the tick carries the last flag.
         if (fresh.size() > 0) begin
            fresh[fresh.size()-1].last = 1'b1;
         end
         foreach (fresh[i]) begin
            owed_events.push_back(fresh[i]);
         end
      endfunction

      function void report(string field, int want, int got);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      // Compares one accepted result word with the oldest owed event.
      function void check_event(logic [RSP_DATA_W-1:0] word, logic last);
         scan_event_type want;
         if (owed_events.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("%0t: unexpected word, expected none, actual %h last %b",
                        $time, word, last);
            end
            return;
         end
         want = owed_events.pop_front();
         if (word[2:0] != want.key) begin
            report("key_index", want.key, word[2:0]);
         end
         if (word[5:3] != want.kind) begin
            report("event_kind", want.kind, word[5:3]);
         end
         if (last != want.last) begin
            report("last_event", want.last, last);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   key_event_tracker tracker;

   int calm = 0;
   int hold_off_request = 0;
   int hold_off_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   // Per-key press pattern state of the stimulus generator.
   int press_left [KEY_COUNT];
   int gap_left [KEY_COUNT];

   key_press_event_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Result side readiness: a long hold-off on request, random stall bursts otherwise.
   always @(negedge clock) begin
      if (hold_off_request != 0) begin
         hold_off_request = 0;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (calm == 0 && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: accepted ticks, register writes, accepted events and the watchdog.
   // A tick sees the timing registers as they were before the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_tick(req_tdata[LEVEL_W-1:0]);
         end
         if (csr_wen) begin
            tracker.set_reg(csr_index, csr_wdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_event(rsp_tdata, rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_key_press_event_scanner NOT OK");
            $finish;
         end
      end
   end

   // Offers one tick word and returns at the edge that accepts it.
   task automatic send_tick(input logic [LEVEL_W-1:0] levels);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-LEVEL_W){1'b0}}, levels};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_ticks(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Stops sending and waits until every owed event has come, then lets the
   // block settle so that a tick without events is surely finished.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.owed_events.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Press length aimed at one of the phases under the current timing.
   function automatic int pick_press();
      int d;
      int l;
      int r;
      int base;
      int len;
      d = (tracker.cfg.debounce_ticks == 0) ? 1 : int'(tracker.cfg.debounce_ticks);
      l = int'(tracker.cfg.long_press_ticks);
      r = int'(tracker.cfg.repeat_ticks);
      base = 1 + d;
      case ($urandom_range(0, 3))
         0:       len = $urandom_range(1, base);
         1:       len = $urandom_range(base, base + l);
         2:       len = $urandom_range(base + l, base + l + 3 * r + 1);
         default: len = $urandom_range(1, 3);
      endcase
      if (len > HOLD_CAP) begin
         len = $urandom_range(1, HOLD_CAP);
      end
      return len;
   endfunction

   // Mostly well-formed press and release runs per key, with some noise words.
   function automatic logic [LEVEL_W-1:0] next_levels();
      logic [LEVEL_W-1:0] levels;
      levels = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (press_left[k] == 0 && gap_left[k] == 0) begin
            press_left[k] = pick_press();
         end
         if (press_left[k] > 0) begin
            levels[k] = 1'b1;
            press_left[k]--;
            if (press_left[k] == 0) begin
               gap_left[k] = $urandom_range(1, 3);
            end
         end else begin
            gap_left[k]--;
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         levels = LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
      end
      return levels;
   endfunction

   // One random phase under fixed timing registers.
   task automatic run_phase(input int deb, input int lng, input int rpt,
                            input bit squeeze, input bit quiet);
      calm = quiet;
      write_reg(CSR_DEBOUNCE, CSR_DATA_W'(deb));
      write_reg(CSR_LONG_PRESS, CSR_DATA_W'(lng));
      write_reg(CSR_REPEAT, CSR_DATA_W'(rpt));
      for (int k = 0; k < KEY_COUNT; k++) begin
         press_left[k] = 0;
         gap_left[k]   = $urandom_range(0, 2);
      end
      if (squeeze) begin
         hold_off_request = 1;
      end
      for (int i = 0; i < PHASE_TICKS; i++) begin
         if (calm == 0 && $urandom_range(0, 5) == 0) begin
            idle_ticks($urandom_range(1, 11));
         end
         send_tick(next_levels());
      end
      wait_drained();
   endtask

   initial begin
      tracker = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset timing: an empty tick, all six keys clicking on one tick, then all released.
      send_tick('0);
      repeat (4) send_tick(6'h3F);
      send_tick('0);
      wait_drained();

      // Zero debounce acts as one; shortest long press and repeat.
      write_reg(CSR_DEBOUNCE, 16'd0);
      write_reg(CSR_LONG_PRESS, 16'd1);
      write_reg(CSR_REPEAT, 16'd1);
      send_tick(6'h3F);
      repeat (3) send_tick(6'h2A);
      send_tick(6'h15);
      send_tick('0);
      wait_drained();

      // Longest long press and repeat timing, then lower the long press limit below the running count.
      write_reg(CSR_DEBOUNCE, 16'd1);
      write_reg(CSR_LONG_PRESS, 16'hFFFF);
      write_reg(CSR_REPEAT, 16'hFFFF);
      repeat (8) send_tick(6'h01);
      wait_drained();
      write_reg(CSR_LONG_PRESS, 16'd4);
      send_tick(6'h01);
      repeat (2) send_tick(6'h01);
      wait_drained();

      // Same for repeat; a write to the unused index must leave it at two.
      write_reg(CSR_REPEAT, 16'd2);
      send_tick(6'h01);
      wait_drained();
      write_reg(CSR_UNUSED, 16'd1);
      repeat (2) send_tick(6'h01);
      send_tick('0);
      wait_drained();

      // Random phases; the first one also holds the result side off for a long stretch.
      run_phase(1, 1, 1, 1'b1, 1'b0);
      run_phase(2, 4, 3, 1'b0, 1'b0);
      run_phase($urandom_range(1, 4), $urandom_range(1, 12), $urandom_range(1, 6),
                1'b0, 1'b0);
      run_phase(2, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      run_phase($urandom_range(1, 3), $urandom_range(1, 8), $urandom_range(1, 4),
                1'b0, 1'b1);

      if (tracker.errors == 0) begin
         $display("tb_key_press_event_scanner OK");
      end else begin
         $display("tb_key_press_event_scanner NOT OK");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/kpes_pkg.sv
hw/rtl/kpes_lane.sv
hw/rtl/kpes_merge.sv
hw/rtl/key_press_event_scanner.sv
verif/tb_key_press_event_scanner.sv
